FILE: hdl/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types and constants of the Ethernet destination filter.
// ----------------------------------------------------------------------------
package edf_pkg;

    localparam int ADDR_W            = 48;
    localparam int ENTRY_IDX_W       = 5;
    localparam int COUNT_W           = 6;
    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int TABLE_ENTRIES_MAX = 64;
    localparam int LIMIT_W           = 7;
    localparam int GROUP_BIT         = 40;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    typedef enum logic [2:0] {
        REASON_REJECT    = 3'd0,
        REASON_BROADCAST = 3'd1,
        REASON_OWN       = 3'd2,
        REASON_PROMISC   = 3'd3,
        REASON_ALLMULTI  = 3'd4,
        REASON_TABLE     = 3'd5
    } reason_t;

    typedef enum logic [1:0] {
        REG_STATION_ADDRESS = 2'd0,
        REG_PROMISCUOUS     = 2'd1,
        REG_ALL_MULTICAST   = 2'd2,
        REG_ENTRIES_USED    = 2'd3
    } reg_index_t;

    typedef enum logic {
        REQ_CHECK = 1'b0,
        REQ_WRITE = 1'b1
    } req_type_t;

    typedef struct packed {
        logic    capture;
        logic    scan_start;
        logic    issue;
        logic    set_reason;
        reason_t reason;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic    in_is_write;
        logic    need_scan;
        logic    limit_zero;
        reason_t fast_reason;
        logic    hit;
        logic    scan_done;
        logic    out_free;
    } dp_status_t;

endpackage

FILE: hdl/edf_ctrl.sv
// ----------------------------------------------------------------------------
// edf_ctrl
// Sequencer: input transaction, rule evaluation, table scan, result load.
// ----------------------------------------------------------------------------
module edf_ctrl
    import edf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EVAL   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.reason     = REASON_REJECT;
        s_tready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (!status.in_is_write) begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                cmd.set_reason = 1'b1;
                cmd.reason     = status.fast_reason;
                if (status.need_scan && !status.limit_zero) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (status.hit) begin
                    cmd.set_reason = 1'b1;
                    cmd.reason     = REASON_TABLE;
                    state_next     = ST_FINISH;
                end else if (status.scan_done) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.issue = 1'b1;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/edf_datapath.sv
// ----------------------------------------------------------------------------
// edf_datapath
// Address register, multicast table memory, rule logic and result register.
// ----------------------------------------------------------------------------
module edf_datapath
    import edf_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_req_type,
    input  logic [ENTRY_IDX_W-1:0] in_entry_index,
    input  logic [ADDR_W-1:0]      in_dest_addr,
    input  logic [ADDR_W-1:0]      station_address,
    input  logic                   promiscuous_mode,
    input  logic                   all_multicast_mode,
    input  logic [COUNT_W-1:0]     multicast_entries_used,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_accept,
    output logic [2:0]             out_reason
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [LIMIT_W-1:0] ENTRIES_L = LIMIT_W'(TABLE_ENTRIES);

    logic [ADDR_W-1:0] table_mem [TABLE_ENTRIES];

    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              pend_reg;
    reason_t           reason_reg;
    logic              out_valid_reg;
    logic              out_accept_reg;
    reason_t           out_reason_reg;

    logic [LIMIT_W-1:0] wr_idx_ext;
    logic [LIMIT_W-1:0] count_ext;
    logic [LIMIT_W-1:0] limit_ext;
    logic [CNT_W-1:0]   limit;
    logic               wr_in_range;
    logic               all_issued;

    assign wr_idx_ext  = LIMIT_W'(in_entry_index);
    assign wr_in_range = wr_idx_ext < ENTRIES_L;
    assign count_ext   = LIMIT_W'(multicast_entries_used);
    assign limit_ext   = (count_ext > ENTRIES_L) ? ENTRIES_L : count_ext;
    assign limit       = limit_ext[CNT_W-1:0];
    assign all_issued  = idx_reg == limit;

    // table write at input transaction, registered read during scan
    always_ff @(posedge aclk) begin
        if (cmd.capture && in_req_type == REQ_WRITE && wr_in_range) begin
            table_mem[wr_idx_ext[IDX_W-1:0]] <= in_dest_addr;
        end
        if (cmd.issue && !all_issued) begin
            rd_data_reg <= table_mem[idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            addr_reg <= in_dest_addr;
        end
        if (cmd.set_reason) begin
            reason_reg <= cmd.reason;
        end
        if (cmd.load_out) begin
            out_accept_reg <= reason_reg != REASON_REJECT;
            out_reason_reg <= reason_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.scan_start) begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end else if (cmd.issue) begin
                pend_reg <= !all_issued;
                if (!all_issued) begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // fixed-priority rules ahead of the table scan
    always_comb begin
        status.in_is_write = in_req_type == REQ_WRITE;
        status.limit_zero  = limit == '0;
        status.hit         = pend_reg && (rd_data_reg == addr_reg);
        status.scan_done   = all_issued && !pend_reg;
        status.out_free    = !out_valid_reg || out_ready;
        status.need_scan   = 1'b0;
        status.fast_reason = REASON_REJECT;
        priority if (addr_reg == {ADDR_W{1'b1}}) begin
            status.fast_reason = REASON_BROADCAST;
        end else if (addr_reg == station_address) begin
            status.fast_reason = REASON_OWN;
        end else if (promiscuous_mode) begin
            status.fast_reason = REASON_PROMISC;
        end else if (!addr_reg[GROUP_BIT]) begin
            status.fast_reason = REASON_REJECT;
        end else if (all_multicast_mode) begin
            status.fast_reason = REASON_ALLMULTI;
        end else begin
            status.need_scan = 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_accept = out_accept_reg;
    assign out_reason = out_reason_reg;

endmodule

FILE: hdl/ethernet_destination_filter.sv
// ----------------------------------------------------------------------------
// ethernet_destination_filter
// Receive destination address filter with an exact-match multicast table.
// ----------------------------------------------------------------------------
// Input stream (s_): one transaction per request. s_tuser selects a check of
// the destination in s_tdata or a write of a multicast table entry. A check
// gives one result transaction on m_ (accept flag and deciding rule); a
// table write gives none and is taken at one per cycle while no check is in
// flight. The user must write the registers over the APB port only while no
// check is in flight; the block itself does not enforce it. A check is
// captured at its accepting edge, then passes through the fixed rules, a
// table scan where needed (one entry read from the table memory per cycle,
// over the entries in use capped at the table size) and the load of the
// result register. s_tready rises with m_tvalid, so a new request is taken
// only once the previous check has loaded its result.
// The result register lets a new request be taken while the previous
// result is still held; if the receiver stalls, the next check waits in its
// final step until the result register frees.
// Synchronous reset clears the APB registers, the result valid flag and the
// control state; table contents are undefined until written.
// ----------------------------------------------------------------------------
module ethernet_destination_filter
    import edf_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // entry_index[4:0], dest_addr[52:5]
    input  logic [S_TUSER_W-1:0]  s_tuser,   // req_type[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // accept[0], match_reason[3:1]
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [ADDR_W-1:0]  station_address_reg;
    logic               promiscuous_reg;
    logic               all_multicast_reg;
    logic [COUNT_W-1:0] entries_used_reg;

    reg_index_t reg_sel;
    logic       cfg_write;

    dp_cmd_t    cmd;
    dp_status_t status;

    logic       out_accept;
    logic [2:0] out_reason;

    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[4:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_address_reg <= '0;
            promiscuous_reg     <= 1'b0;
            all_multicast_reg   <= 1'b0;
            entries_used_reg    <= '0;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_STATION_ADDRESS: station_address_reg <= pwdata[ADDR_W-1:0];
                REG_PROMISCUOUS:     promiscuous_reg     <= pwdata[0];
                REG_ALL_MULTICAST:   all_multicast_reg   <= pwdata[0];
                REG_ENTRIES_USED:    entries_used_reg    <= pwdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_STATION_ADDRESS: prdata = APB_DATA_W'(station_address_reg);
            REG_PROMISCUOUS:     prdata = APB_DATA_W'(promiscuous_reg);
            REG_ALL_MULTICAST:   prdata = APB_DATA_W'(all_multicast_reg);
            REG_ENTRIES_USED:    prdata = APB_DATA_W'(entries_used_reg);
            default:             prdata = '0;
        endcase
    end

    edf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    edf_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .in_req_type            (s_tuser[0]),
        .in_entry_index         (s_tdata[ENTRY_IDX_W-1:0]),
        .in_dest_addr           (s_tdata[ENTRY_IDX_W +: ADDR_W]),
        .station_address        (station_address_reg),
        .promiscuous_mode       (promiscuous_reg),
        .all_multicast_mode     (all_multicast_reg),
        .multicast_entries_used (entries_used_reg),
        .cmd                    (cmd),
        .status                 (status),
        .out_valid              (m_tvalid),
        .out_ready              (m_tready),
        .out_accept             (out_accept),
        .out_reason             (out_reason)
    );

    assign m_tdata = {4'b0000, out_reason, out_accept};

endmodule

FILE: dv/edf_checker.sv
// ----------------------------------------------------------------------------
// edf_checker
// Watches the input, result and APB ports of the destination filter. It
// keeps its own copy of the registers and of the multicast table, works out
// the verdict for each accepted check, and compares every result transaction
// with the oldest verdict still owed.
// ----------------------------------------------------------------------------
module edf_checker
    import edf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // entry_index[4:0], dest_addr[52:5]
    input  logic [S_TUSER_W-1:0]  s_tuser,   // req_type[0]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // accept[0], match_reason[3:1]
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatches,
    output int                    verdicts_pending
);

    typedef struct packed {
        logic    accept;
        reason_t reason;
    } verdict_t;

    logic [ADDR_W-1:0]  station_addr;
    logic               promisc_on;
    logic               allmulti_on;
    logic [COUNT_W-1:0] entries_used;
    logic [ADDR_W-1:0]  mcast_table [TABLE_ENTRIES_DEF];
    verdict_t           verdict_q [$];
    int                 results_seen;

    function automatic reason_t filter_reason(input logic [ADDR_W-1:0] dest);
        int span;
        span = (entries_used > TABLE_ENTRIES_DEF) ? TABLE_ENTRIES_DEF : int'(entries_used);
        if (dest == {ADDR_W{1'b1}}) return REASON_BROADCAST;
        if (dest == station_addr) return REASON_OWN;
        if (promisc_on) return REASON_PROMISC;
        if (!dest[GROUP_BIT]) return REASON_REJECT;
        if (allmulti_on) return REASON_ALLMULTI;
        for (int k = 0; k < span; k++) begin
            if (mcast_table[k] == dest) return REASON_TABLE;
        end
        return REASON_REJECT;
    endfunction

    always @(posedge aclk) begin : watch
        verdict_t          want;
        verdict_t          got;
        reason_t           why;
        logic [ADDR_W-1:0] addr;
        if (!aresetn) begin
            station_addr = '0;
            promisc_on   = 1'b0;
            allmulti_on  = 1'b0;
            entries_used = '0;
            verdict_q.delete();
            results_seen = 0;
            mismatches   = 0;
        end else begin
            // results first: a check accepted at this edge cannot be answered yet
            if (m_tvalid && m_tready) begin
                got.accept = m_tdata[0];
                got.reason = reason_t'(m_tdata[3:1]);
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result transaction accept=%0b reason=%0d",
                                 got.accept, got.reason);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.accept !== want.accept || got.reason !== want.reason) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display(
                                {"ERROR: result %0d: expected accept=%0b reason=%0d, ",
                                 "got accept=%0b reason=%0d"},
                                results_seen, want.accept, want.reason,
                                got.accept, got.reason);
                    end
                end
                results_seen++;
            end
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[4:3]))
                    REG_STATION_ADDRESS: station_addr = pwdata[ADDR_W-1:0];
                    REG_PROMISCUOUS:     promisc_on   = pwdata[0];
                    REG_ALL_MULTICAST:   allmulti_on  = pwdata[0];
                    REG_ENTRIES_USED:    entries_used = pwdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                addr = s_tdata[ENTRY_IDX_W +: ADDR_W];
                if (req_type_t'(s_tuser[0]) == REQ_WRITE) begin
                    mcast_table[s_tdata[ENTRY_IDX_W-1:0]] = addr;
                end else begin
                    why         = filter_reason(addr);
                    want.accept = (why != REASON_REJECT);
                    want.reason = why;
                    verdict_q.push_back(want);
                end
            end
        end
        verdicts_pending = verdict_q.size();
    end

endmodule

FILE: dv/tb_ethernet_destination_filter.sv
// ----------------------------------------------------------------------------
// tb_ethernet_destination_filter
// Drives the destination filter through several register settings and
// flow-control phases: a table preload, directed checks of every rule but the
// promiscuous one, then random checks and table writes aimed at table hits and
// near misses. The edf_checker instance predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_ethernet_destination_filter;
    import edf_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 48;
    localparam int HOLD_CYCLES  = 400;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // entry_index[4:0], dest_addr[52:5]
    logic [S_TUSER_W-1:0]  s_tuser;    // req_type[0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;    // accept[0], match_reason[3:1]
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatches;
    int                    verdicts_pending;
    int                    sender_idle_pct;
    int                    receiver_stall_pct;
    bit                    hold_req;
    logic [ADDR_W-1:0]     own_addr;
    logic [ADDR_W-1:0]     table_shadow [TABLE_ENTRIES_DEF];

    ethernet_destination_filter DUT (.*);

    edf_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        bit hold_taken;
        hold_taken = 1'b0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready   = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready = ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [31:0] lo;
        logic [15:0] hi;
        lo = $urandom();
        hi = 16'($urandom());
        return {hi, lo};
    endfunction

    function automatic logic [ADDR_W-1:0] rand_group_addr(input logic grp);
        logic [ADDR_W-1:0] a;
        a            = rand_addr();
        a[GROUP_BIT] = grp;
        return a;
    endfunction

    task automatic send_item(input req_type_t req, input logic [ENTRY_IDX_W-1:0] idx,
                             input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {addr, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (verdicts_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(input reg_index_t r, input logic [APB_DATA_W-1:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'(r) << 3;
        pwdata  = v;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(input logic [ADDR_W-1:0] st, input logic pm, input logic am,
                             input logic [COUNT_W-1:0] cnt);
        wait_drained();
        apb_write(REG_STATION_ADDRESS, APB_DATA_W'(st));
        apb_write(REG_PROMISCUOUS, APB_DATA_W'(pm));
        apb_write(REG_ALL_MULTICAST, APB_DATA_W'(am));
        apb_write(REG_ENTRIES_USED, APB_DATA_W'(cnt));
        own_addr = st;
    endtask

    task automatic random_item();
        logic [ADDR_W-1:0]      a;
        logic [ENTRY_IDX_W-1:0] i;
        int                     pick;
        i    = ENTRY_IDX_W'($urandom_range(TABLE_ENTRIES_DEF - 1));
        pick = $urandom_range(99);
        if (pick < 22) begin
            a               = ($urandom_range(4) == 0) ? rand_addr() : rand_group_addr(1'b1);
            table_shadow[i] = a;
            send_item(REQ_WRITE, i, a);
        end else begin
            pick = $urandom_range(99);
            if (pick < 8)       a = {ADDR_W{1'b1}};
            else if (pick < 16) a = own_addr;
            else if (pick < 50) a = table_shadow[i];
            else if (pick < 58) a = table_shadow[i] ^ (48'd1 << $urandom_range(ADDR_W - 1));
            else if (pick < 78) a = rand_group_addr(1'b1);
            else                a = rand_addr();
            send_item(REQ_CHECK, ENTRY_IDX_W'($urandom()), a);
        end
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] st, input logic pm, input logic am,
                             input logic [COUNT_W-1:0] cnt, input int idle_pct,
                             input int stall_pct, input int n, input bit squeeze);
        configure(st, pm, am, cnt);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        if (squeeze) hold_req = 1'b1;
        repeat (n) random_item();
    endtask

    initial begin : stimulus
        aresetn            = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        s_tuser            = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_req           = 1'b0;
        own_addr           = '0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // no entries in use: fill the whole table before any scan can read it
        configure(48'h02005e123456, 1'b0, 1'b0, 6'd0);
        for (int k = 0; k < TABLE_ENTRIES_DEF; k++) table_shadow[k] = rand_group_addr(1'b1);
        table_shadow[0]                     = 48'h010000000000;
        table_shadow[TABLE_ENTRIES_DEF - 1] = 48'hfffffffffffe;
        for (int k = 0; k < TABLE_ENTRIES_DEF; k++)
            send_item(REQ_WRITE, ENTRY_IDX_W'(k), table_shadow[k]);
        send_item(REQ_CHECK, 5'd0, table_shadow[0]);
        send_item(REQ_CHECK, 5'd31, {ADDR_W{1'b1}});
        send_item(REQ_CHECK, 5'd0, own_addr);
        send_item(REQ_CHECK, 5'd0, '0);
        send_item(REQ_CHECK, 5'd0, 48'hfefffffffffe);

        configure('0, 1'b0, 1'b0, 6'd32);
        send_item(REQ_CHECK, 5'd0, table_shadow[0]);
        send_item(REQ_CHECK, 5'd0, table_shadow[TABLE_ENTRIES_DEF - 1]);
        send_item(REQ_CHECK, 5'd0, '0);
        send_item(REQ_CHECK, 5'd0, {ADDR_W{1'b1}});
        send_item(REQ_CHECK, 5'd0, 48'h010000000001);
        table_shadow[17] = 48'h333300000001;
        send_item(REQ_WRITE, 5'd17, table_shadow[17]);
        send_item(REQ_CHECK, 5'd17, table_shadow[17]);

        // station at all ones: broadcast must still win
        configure({ADDR_W{1'b1}}, 1'b0, 1'b1, 6'd63);
        send_item(REQ_CHECK, 5'd0, {ADDR_W{1'b1}});
        send_item(REQ_CHECK, 5'd0, table_shadow[3]);
        send_item(REQ_CHECK, 5'd0, 48'h020000000000);

        run_phase(rand_group_addr(1'b0), 1'b0, 1'b0, 6'd32, 0, 0, 170, 1'b0);
        run_phase({ADDR_W{1'b1}}, 1'b0, 1'b1, 6'd63, 80, 0, 170, 1'b0);
        run_phase(rand_group_addr(1'b0), 1'b1, 1'b0, 6'd1, 0, 80, 170, 1'b1);
        run_phase(rand_group_addr(1'b0), 1'b0, 1'b0, 6'd17, 38, 38, 170, 1'b0);
        run_phase(rand_group_addr(1'b1), 1'b0, 1'b0, 6'd40, 0, 0, 120, 1'b0);
        run_phase(rand_group_addr(1'b0), 1'b1, 1'b1, 6'd0, 38, 38, 100, 1'b0);

        wait_drained();
        if (mismatches == 0 && verdicts_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
